### src/amm_pkg.sv
`default_nettype none

package amm_pkg;

  // Store sizes
  localparam int SEQ_DEPTH     = 65536;
  localparam int MOTIF_COUNT   = 8;
  localparam int MOTIF_MAX_LEN = 16;

  // Field widths of the beats and the configuration registers
  localparam int POS_W    = 16;
  localparam int MIDX_W   = 3;
  localparam int CIDX_W   = 4;
  localparam int CHAR_W   = 8;
  localparam int MLEN_W   = 5;
  localparam int OFF_W    = 9;
  localparam int SEQLEN_W = 17;
  localparam int MUSE_W   = 4;

  // Derived widths
  localparam int SEQ_AW   = $clog2(SEQ_DEPTH);
  localparam int MC_DEPTH = MOTIF_COUNT * MOTIF_MAX_LEN;
  localparam int MC_AW    = (MC_DEPTH > 1) ? $clog2(MC_DEPTH) : 1;
  localparam int MI_W     = (MOTIF_COUNT > 1) ? $clog2(MOTIF_COUNT) : 1;
  localparam int MCNT_W   = $clog2(MOTIF_COUNT + 1);
  localparam int LEN_W    = $clog2(MOTIF_MAX_LEN + 1);
  localparam int SUM_W    = ((POS_W > SEQLEN_W) ? POS_W : SEQLEN_W) + 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_SEQ_WR   = 2'd0,
    ACT_CHAR_WR  = 2'd1,
    ACT_SHAPE_WR = 2'd2,
    ACT_QUERY    = 2'd3
  } act_t;

  typedef struct packed {
    act_t                     act;
    logic [POS_W-1:0]         position;
    logic [MIDX_W-1:0]        motif_index;
    logic [CIDX_W-1:0]        char_index;
    logic [CHAR_W-1:0]        char_value;
    logic [LEN_W-1:0]         length;
    logic signed [OFF_W-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    logic [SEQLEN_W-1:0] sequence_length;
    logic [MUSE_W-1:0]   motifs_in_use;
  } cfg_t;

  typedef struct packed {
    logic             matched;
    logic [POS_W-1:0] query_position;
  } res_t;

endpackage

`default_nettype wire

### src/amm_ram.sv
`default_nettype none

module amm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### src/amm_front.sv
`default_nettype none

module amm_front (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [amm_pkg::POS_W-1:0]           position,
  input  logic [amm_pkg::MIDX_W-1:0]          motif_index,
  input  logic [amm_pkg::CIDX_W-1:0]          char_index,
  input  logic [amm_pkg::CHAR_W-1:0]          char_value,
  input  logic [amm_pkg::MLEN_W-1:0]          shape_length,
  input  logic signed [amm_pkg::OFF_W-1:0]    motif_offset,
  input  logic                                full,
  output logic                                push,
  output amm_pkg::cmd_t                       cmd
);

  amm_pkg::act_t act;
  logic          keep;

  // Classify the beat; writes to addresses outside the stores are dropped here.
  always_comb begin
    act  = amm_pkg::act_t'(action);
    keep = 1'b0;
    unique case (act)
      amm_pkg::ACT_SEQ_WR:   keep = int'(position) < amm_pkg::SEQ_DEPTH;
      amm_pkg::ACT_CHAR_WR:  keep = (int'(motif_index) < amm_pkg::MOTIF_COUNT) &&
                                    (int'(char_index) < amm_pkg::MOTIF_MAX_LEN);
      amm_pkg::ACT_SHAPE_WR: keep = int'(motif_index) < amm_pkg::MOTIF_COUNT;
      amm_pkg::ACT_QUERY:    keep = 1'b1;
    endcase
  end

  always_comb begin
    cmd.act         = act;
    cmd.position    = position;
    cmd.motif_index = motif_index;
    cmd.char_index  = char_index;
    cmd.char_value  = char_value;
    cmd.offset      = motif_offset;
    // saturate the length to the motif row size
    if (int'(shape_length) > amm_pkg::MOTIF_MAX_LEN) begin
      cmd.length = amm_pkg::LEN_W'(amm_pkg::MOTIF_MAX_LEN);
    end else begin
      cmd.length = amm_pkg::LEN_W'(shape_length);
    end
  end

  assign in_stall = full;
  assign push     = in_valid && !full && keep;

endmodule

`default_nettype wire

### src/amm_queue.sv
`default_nettype none

module amm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  amm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          empty,
  output logic          full,
  output amm_pkg::cmd_t head
);

  amm_pkg::cmd_t                slots [amm_pkg::QUEUE_DEPTH];
  logic [amm_pkg::QP_W-1:0]     wr_ptr;
  logic [amm_pkg::QP_W-1:0]     rd_ptr;
  logic [amm_pkg::QC_W-1:0]     count;
  logic [amm_pkg::QP_W-1:0]     wr_ptr_next;
  logic [amm_pkg::QP_W-1:0]     rd_ptr_next;

  always_comb begin
    wr_ptr_next = (wr_ptr == amm_pkg::QP_W'(amm_pkg::QUEUE_DEPTH - 1)) ? '0
                : wr_ptr + amm_pkg::QP_W'(1);
    rd_ptr_next = (rd_ptr == amm_pkg::QP_W'(amm_pkg::QUEUE_DEPTH - 1)) ? '0
                : rd_ptr + amm_pkg::QP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      unique case ({push, pop})
        2'b10:   count <= count + amm_pkg::QC_W'(1);
        2'b01:   count <= count - amm_pkg::QC_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  assign empty = (count == '0);
  assign full  = (count == amm_pkg::QC_W'(amm_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

endmodule

`default_nettype wire

### src/amm_back.sv
`default_nettype none

module amm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  amm_pkg::cmd_t head,
  output logic          pop,
  input  amm_pkg::cfg_t cfg,
  input  logic          out_stall,
  output logic          out_valid,
  output amm_pkg::res_t res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t                            state;
  logic [amm_pkg::MCNT_W-1:0]        m;
  logic                              hit;
  logic [amm_pkg::POS_W-1:0]         pos_r;
  logic [amm_pkg::SUM_W-1:0]         start_r;
  logic [amm_pkg::LEN_W-1:0]         len_r;
  logic [amm_pkg::LEN_W-1:0]         iss_k;
  logic                              pend;
  logic                              last;
  logic [amm_pkg::LEN_W-1:0]         len_tab [amm_pkg::MOTIF_COUNT];
  logic signed [amm_pkg::OFF_W-1:0]  off_tab [amm_pkg::MOTIF_COUNT];
  logic                              res_valid;
  amm_pkg::res_t                     res_r;

  logic                              seq_we;
  logic                              mc_we;
  logic [amm_pkg::SEQ_AW-1:0]        seq_addr;
  logic [amm_pkg::MC_AW-1:0]         mc_addr;
  logic [amm_pkg::CHAR_W-1:0]        seq_rdata;
  logic [amm_pkg::CHAR_W-1:0]        mc_rdata;

  logic [amm_pkg::MI_W-1:0]          cur;
  logic [amm_pkg::LEN_W-1:0]         cur_len;
  logic signed [amm_pkg::OFF_W-1:0]  cur_off;
  logic signed [amm_pkg::SUM_W-1:0]  start_c;
  logic [amm_pkg::SUM_W-1:0]         end_c;
  logic [amm_pkg::SEQLEN_W-1:0]      seq_len_eff;
  logic [amm_pkg::MCNT_W-1:0]        count_eff;
  logic                              fits_c;
  logic                              more_c;
  logic                              issue;
  logic                              last_c;
  logic                              mismatch;

  assign pop    = (state == ST_IDLE) && !empty;
  assign seq_we = pop && (head.act == amm_pkg::ACT_SEQ_WR);
  assign mc_we  = pop && (head.act == amm_pkg::ACT_CHAR_WR);

  // Loads use the port while idle; the walk owns it otherwise.
  always_comb begin
    if (state == ST_IDLE) begin
      seq_addr = amm_pkg::SEQ_AW'(head.position);
      mc_addr  = amm_pkg::MC_AW'(int'(head.motif_index) * amm_pkg::MOTIF_MAX_LEN +
                                 int'(head.char_index));
    end else begin
      seq_addr = amm_pkg::SEQ_AW'(start_r + amm_pkg::SUM_W'(iss_k));
      mc_addr  = amm_pkg::MC_AW'(int'(m) * amm_pkg::MOTIF_MAX_LEN + int'(iss_k));
    end
  end

  amm_ram #(
    .WIDTH (amm_pkg::CHAR_W),
    .DEPTH (amm_pkg::SEQ_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .addr  (seq_addr),
    .wdata (head.char_value),
    .rdata (seq_rdata)
  );

  amm_ram #(
    .WIDTH (amm_pkg::CHAR_W),
    .DEPTH (amm_pkg::MC_DEPTH)
  ) u_motif_ram (
    .clk   (clk),
    .we    (mc_we),
    .addr  (mc_addr),
    .wdata (head.char_value),
    .rdata (mc_rdata)
  );

  always_comb begin
    if (int'(cfg.sequence_length) > amm_pkg::SEQ_DEPTH) begin
      seq_len_eff = amm_pkg::SEQLEN_W'(amm_pkg::SEQ_DEPTH);
    end else begin
      seq_len_eff = cfg.sequence_length;
    end
    if (int'(cfg.motifs_in_use) > amm_pkg::MOTIF_COUNT) begin
      count_eff = amm_pkg::MCNT_W'(amm_pkg::MOTIF_COUNT);
    end else begin
      count_eff = amm_pkg::MCNT_W'(cfg.motifs_in_use);
    end
  end

  // Window check for motif m: non-empty, start not negative, end inside the sequence.
  always_comb begin
    cur     = amm_pkg::MI_W'(m);
    cur_len = len_tab[cur];
    cur_off = off_tab[cur];
    start_c = $signed(amm_pkg::SUM_W'(pos_r)) - amm_pkg::SUM_W'(cur_off);
    end_c   = start_c + amm_pkg::SUM_W'(cur_len);
    fits_c  = (cur_len != '0) && !start_c[amm_pkg::SUM_W-1] &&
              (end_c <= amm_pkg::SUM_W'(seq_len_eff));
    more_c  = m < count_eff;
  end

  assign issue    = iss_k < len_r;
  assign last_c   = (iss_k + amm_pkg::LEN_W'(1)) == len_r;
  assign mismatch = seq_rdata != mc_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m         <= '0;
      hit       <= 1'b0;
      pos_r     <= '0;
      start_r   <= '0;
      len_r     <= '0;
      iss_k     <= '0;
      pend      <= 1'b0;
      last      <= 1'b0;
      res_valid <= 1'b0;
      res_r     <= '0;
      for (int i = 0; i < amm_pkg::MOTIF_COUNT; i++) begin
        len_tab[i] <= '0;
        off_tab[i] <= '0;
      end
    end else begin
      if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            unique case (head.act)
              amm_pkg::ACT_SEQ_WR, amm_pkg::ACT_CHAR_WR: begin
              end
              amm_pkg::ACT_SHAPE_WR: begin
                len_tab[amm_pkg::MI_W'(head.motif_index)] <= head.length;
                off_tab[amm_pkg::MI_W'(head.motif_index)] <= head.offset;
              end
              amm_pkg::ACT_QUERY: begin
                pos_r <= head.position;
                m     <= '0;
                hit   <= 1'b0;
                state <= ST_CHECK;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (!more_c) begin
            state <= ST_FINISH;
          end else if (fits_c) begin
            start_r <= start_c;
            len_r   <= cur_len;
            iss_k   <= '0;
            pend    <= 1'b0;
            state   <= ST_WALK;
          end else begin
            m <= m + amm_pkg::MCNT_W'(1);
          end
        end
        ST_WALK: begin
          // one read issued and one compare retired per cycle
          if (issue) begin
            iss_k <= iss_k + amm_pkg::LEN_W'(1);
          end
          pend <= issue;
          last <= last_c;
          if (pend && mismatch) begin
            m     <= m + amm_pkg::MCNT_W'(1);
            pend  <= 1'b0;
            state <= ST_CHECK;
          end else if (pend && last) begin
            hit   <= 1'b1;
            pend  <= 1'b0;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || !out_stall) begin
            res_valid            <= 1'b1;
            res_r.matched        <= hit;
            res_r.query_position <= pos_r;
            state                <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid = res_valid;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && head.act != amm_pkg::ACT_QUERY) |=> state == ST_IDLE)
    else $error("load beat left the back end busy");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (pop && head.act == amm_pkg::ACT_QUERY) |=> (state == ST_CHECK && m == '0))
    else $error("query did not start at the first motif");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> (iss_k <= len_r && len_r != '0))
    else $error("walk ran past the motif length");

  a_motif_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> m <= count_eff)
    else $error("motif counter overran the motifs in use");
`endif

endmodule

`default_nettype wire

### src/anchored_motif_match_checker.sv
`default_nettype none

// Anchored motif match checker. Load beats (action 0, 1, 2) fill the sequence
// store, the motif character rows, and each motif's length and offset; they
// give no result. A query beat (action 3) gives exactly one result beat: matched
// is set when some motif among the first motifs_in_use has a window at
// position - offset that is non-empty, starts at or above zero, ends within
// sequence_length and equals the stored sequence character for character.
// Beats enter a two-entry command queue and are executed one at a time by the
// back end, which owns a single-port sequence RAM and a motif RAM. A query
// has a start step, then for each motif checked a window test plus, where the
// window fits, a compare of one character per cycle (stopping at the first
// mismatch or on the first motif that matches), a closing check step when no
// motif matched, and a step to load the result register once it is free.
// The result register lets the next beat be taken while a result waits.
// Stores have no clearing pass after reset; reading a character that was
// never written gives an undefined compare.
// Registers: sequence_length at 0x0, motifs_in_use at 0x4; pready is always
// high and writes should be made only while the block is idle.
module anchored_motif_match_checker (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [amm_pkg::POS_W-1:0]         position,
  input  logic [amm_pkg::MIDX_W-1:0]        motif_index,
  input  logic [amm_pkg::CIDX_W-1:0]        char_index,
  input  logic [amm_pkg::CHAR_W-1:0]        char_value,
  input  logic [amm_pkg::MLEN_W-1:0]        shape_length,
  input  logic signed [amm_pkg::OFF_W-1:0]  motif_offset,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              matched,
  output logic [amm_pkg::POS_W-1:0]         query_position,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic {
    REG_SEQ_LEN = 1'b0,
    REG_MOTIFS  = 1'b1
  } reg_t;

  logic [amm_pkg::SEQLEN_W-1:0] sequence_length;
  logic [amm_pkg::MUSE_W-1:0]   motifs_in_use;
  logic                         cfg_wr;
  reg_t                         reg_sel;
  amm_pkg::cfg_t                cfg;

  logic                         q_push;
  amm_pkg::cmd_t                q_push_cmd;
  logic                         q_pop;
  logic                         q_empty;
  logic                         q_full;
  amm_pkg::cmd_t                q_head;
  amm_pkg::res_t                res;

  // Register file: word index taken from paddr[2].
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_length <= '0;
      motifs_in_use   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SEQ_LEN: sequence_length <= pwdata[amm_pkg::SEQLEN_W-1:0];
        REG_MOTIFS:  motifs_in_use   <= pwdata[amm_pkg::MUSE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SEQ_LEN: prdata = 32'(sequence_length);
      REG_MOTIFS:  prdata = 32'(motifs_in_use);
    endcase
  end

  assign cfg.sequence_length = sequence_length;
  assign cfg.motifs_in_use   = motifs_in_use;

  // Front: accept and classify each input beat, drop out-of-range loads.
  amm_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .position     (position),
    .motif_index  (motif_index),
    .char_index   (char_index),
    .char_value   (char_value),
    .shape_length (shape_length),
    .motif_offset (motif_offset),
    .full         (q_full),
    .push         (q_push),
    .cmd          (q_push_cmd)
  );

  // Hold commands between front and back so each side stalls on its own.
  amm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .empty    (q_empty),
    .full     (q_full),
    .head     (q_head)
  );

  // Back: apply loads, walk queries and register the result beat.
  amm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .cfg       (cfg),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign matched        = res.matched;
  assign query_position = res.query_position;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Register map: word index times the stride gives the byte address
  localparam int REG_SEQ_LEN = 0;
  localparam int REG_IN_USE  = 1;
  localparam int REG_STRIDE  = 4;

  // Leave plenty of room after the last result so trailing loads have finished
  // before a register write
  localparam int DRAIN_CYCLES = 200;
  // Receiver hold-off long enough to fill the command queue and result register
  localparam int LONG_HOLD    = 600;
  // Run ceiling, several times the slowest legal run
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POS_MAX      = (1 << amm_pkg::POS_W) - 1;

  // Tracks the block's state from accepted beats and predicts every query result
  class match_scoreboard;
    logic [amm_pkg::CHAR_W-1:0]   seq_mem     [amm_pkg::SEQ_DEPTH];
    bit                           seq_known   [amm_pkg::SEQ_DEPTH];
    logic [amm_pkg::CHAR_W-1:0]   motif_mem   [amm_pkg::MOTIF_COUNT][amm_pkg::MOTIF_MAX_LEN];
    bit                           motif_known [amm_pkg::MOTIF_COUNT][amm_pkg::MOTIF_MAX_LEN];
    int                           mlen        [amm_pkg::MOTIF_COUNT];
    int                           moff        [amm_pkg::MOTIF_COUNT];
    logic [amm_pkg::SEQLEN_W-1:0] seq_len_reg = '0;
    logic [amm_pkg::MUSE_W-1:0]   in_use_reg  = '0;
    amm_pkg::res_t                due_results [$];
    int                           errors = 0;

    function int eff_len();
      return (seq_len_reg > amm_pkg::SEQ_DEPTH) ? amm_pkg::SEQ_DEPTH : int'(seq_len_reg);
    endfunction

    function int eff_count();
      return (in_use_reg > amm_pkg::MOTIF_COUNT) ? amm_pkg::MOTIF_COUNT : int'(in_use_reg);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // True when motif m has a non-empty window inside the sequence at pos
    function bit motif_window(int m, int pos, output int start);
      start = pos - moff[m];
      return (mlen[m] != 0) && (start >= 0) && (start + mlen[m] <= eff_len());
    endfunction

    function bit predict_match(int pos);
      int start;
      bit hit;
      for (int m = 0; m < eff_count(); m++) begin
        if (motif_window(m, pos, start)) begin
          hit = 1'b1;
          for (int k = 0; k < mlen[m]; k++)
            if (seq_mem[start + k] !== motif_mem[m][k]) hit = 1'b0;
          if (hit) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void set_register(int idx, logic [31:0] value);
      if (idx == REG_SEQ_LEN) seq_len_reg = value[amm_pkg::SEQLEN_W-1:0];
      else if (idx == REG_IN_USE) in_use_reg = value[amm_pkg::MUSE_W-1:0];
    endfunction

    function void note_beat(amm_pkg::act_t a, logic [amm_pkg::POS_W-1:0] pos,
                            logic [amm_pkg::MIDX_W-1:0] mi,
                            logic [amm_pkg::CIDX_W-1:0] ci,
                            logic [amm_pkg::CHAR_W-1:0] cv,
                            logic [amm_pkg::MLEN_W-1:0] ml,
                            logic signed [amm_pkg::OFF_W-1:0] mo);
      amm_pkg::res_t r;
      case (a)
        amm_pkg::ACT_SEQ_WR: begin
          if (int'(pos) < amm_pkg::SEQ_DEPTH) begin
            seq_mem[pos]   = cv;
            seq_known[pos] = 1'b1;
          end
        end
        amm_pkg::ACT_CHAR_WR: begin
          if (int'(mi) < amm_pkg::MOTIF_COUNT && int'(ci) < amm_pkg::MOTIF_MAX_LEN) begin
            motif_mem[mi][ci]   = cv;
            motif_known[mi][ci] = 1'b1;
          end
        end
        amm_pkg::ACT_SHAPE_WR: begin
          if (int'(mi) < amm_pkg::MOTIF_COUNT) begin
            mlen[mi] = (ml > amm_pkg::MOTIF_MAX_LEN) ? amm_pkg::MOTIF_MAX_LEN : int'(ml);
            moff[mi] = mo;
          end
        end
        default: begin
          r.matched        = predict_match(int'(pos));
          r.query_position = pos;
          due_results.push_back(r);
        end
      endcase
    endfunction

    function void check_result(logic m, logic [amm_pkg::POS_W-1:0] qp);
      amm_pkg::res_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no query outstanding, matched %0b position %0d",
                 $time, m, qp);
        return;
      end
      want = due_results.pop_front();
      if (m !== want.matched) begin
        errors++;
        $display("%0t: matched mismatch at position %0d: expected %0b actual %0b",
                 $time, want.query_position, want.matched, m);
      end
      if (qp !== want.query_position) begin
        errors++;
        $display("%0t: query_position mismatch: expected %0d actual %0d",
                 $time, want.query_position, qp);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [1:0]                       action = '0;
  logic [amm_pkg::POS_W-1:0]        position = '0;
  logic [amm_pkg::MIDX_W-1:0]       motif_index = '0;
  logic [amm_pkg::CIDX_W-1:0]       char_index = '0;
  logic [amm_pkg::CHAR_W-1:0]       char_value = '0;
  logic [amm_pkg::MLEN_W-1:0]       shape_length = '0;
  logic signed [amm_pkg::OFF_W-1:0] motif_offset = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             matched;
  logic [amm_pkg::POS_W-1:0]        query_position;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [2:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  match_scoreboard sb = new;

  // Shared pacing: quiet stretches drop the drawn gaps on both sides
  bit quiet = 1'b0;
  // Receiver hold-off request, counted down by the result sink itself
  int rx_hold_left = 0;
  int beats_sent = 0;

  anchored_motif_match_checker DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .position       (position),
    .motif_index    (motif_index),
    .char_index     (char_index),
    .char_value     (char_value),
    .shape_length   (shape_length),
    .motif_offset   (motif_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .matched        (matched),
    .query_position (query_position),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Offer one beat. Entered just after a falling edge and left just after one,
  // with valid still high so a back-to-back beat only swaps the payload.
  // Fields the action ignores are filled with noise.
  task automatic send_beat(input amm_pkg::act_t a, input int pos, input int mi,
                           input int ci, input int cv, input int ml, input int mo);
    int gap;
    case (a)
      amm_pkg::ACT_SEQ_WR: begin
        mi = $urandom; ci = $urandom; ml = $urandom; mo = $urandom;
      end
      amm_pkg::ACT_CHAR_WR: begin
        pos = $urandom; ml = $urandom; mo = $urandom;
      end
      amm_pkg::ACT_SHAPE_WR: begin
        pos = $urandom; ci = $urandom; cv = $urandom;
      end
      default: begin
        mi = $urandom; ci = $urandom; cv = $urandom; ml = $urandom; mo = $urandom;
      end
    endcase
    if ($urandom_range(0, 59) == 0) quiet = !quiet;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action       = a;
    position     = pos[amm_pkg::POS_W-1:0];
    motif_index  = mi[amm_pkg::MIDX_W-1:0];
    char_index   = ci[amm_pkg::CIDX_W-1:0];
    char_value   = cv[amm_pkg::CHAR_W-1:0];
    shape_length = ml[amm_pkg::MLEN_W-1:0];
    motif_offset = mo[amm_pkg::OFF_W-1:0];
    in_valid     = 1'b1;
    // hold the payload until the block takes it
    do @(posedge clk); while (in_stall);
    sb.note_beat(a, position, motif_index, char_index, char_value, shape_length,
                 motif_offset);
    beats_sent++;
    @(negedge clk);
  endtask

  // Before a query, fill every character that some live window would compare
  // and that has never been written, so no compare touches undefined storage.
  // Sequence fill copies the motif half the time to seed extra hits.
  task automatic send_query(input int pos);
    int start;
    for (int m = 0; m < sb.eff_count(); m++) begin
      if (sb.motif_window(m, pos, start)) begin
        for (int k = 0; k < sb.mlen[m]; k++) begin
          if (!sb.motif_known[m][k])
            send_beat(amm_pkg::ACT_CHAR_WR, 0, m, k, $urandom, 0, 0);
          if (!sb.seq_known[start + k])
            send_beat(amm_pkg::ACT_SEQ_WR, start + k, 0, 0,
                      $urandom_range(0, 1) ? int'(sb.motif_mem[m][k]) : $urandom, 0, 0);
        end
      end
    end
    send_beat(amm_pkg::ACT_QUERY, pos, 0, 0, 0, 0, 0);
  endtask

  function automatic int random_query_pos();
    int hi;
    hi = sb.eff_len() + 24;
    if (hi > POS_MAX) hi = POS_MAX;
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return POS_MAX;
      4:       return $urandom_range(0, POS_MAX);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Well-formed sequence: shape a live motif, make sure its characters exist,
  // copy it into the sequence (now and then with one bit flipped) and query
  // at the anchored candidate.
  task automatic plant_and_query();
    int cnt, m, top, len, start, pos, flip;
    logic [amm_pkg::CHAR_W-1:0] v;
    cnt = sb.eff_count();
    m   = (cnt > 0) ? $urandom_range(0, cnt - 1)
                    : $urandom_range(0, amm_pkg::MOTIF_COUNT - 1);
    top = (sb.eff_len() > amm_pkg::MOTIF_MAX_LEN) ? amm_pkg::MOTIF_MAX_LEN : sb.eff_len();
    if (top < 1) begin
      send_query(random_query_pos());
      return;
    end
    if (sb.mlen[m] == 0 || sb.mlen[m] > sb.eff_len() || $urandom_range(0, 3) == 0)
      send_beat(amm_pkg::ACT_SHAPE_WR, 0, m, 0, 0, $urandom_range(1, top),
                ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 40)) - 20
                                            : int'($urandom_range(0, 511)));
    len = sb.mlen[m];
    for (int k = 0; k < len; k++)
      if (!sb.motif_known[m][k])
        send_beat(amm_pkg::ACT_CHAR_WR, 0, m, k, $urandom, 0, 0);
    case ($urandom_range(0, 3))
      0:       start = 0;
      1:       start = sb.eff_len() - len;
      default: start = $urandom_range(0, sb.eff_len() - len);
    endcase
    pos = start + sb.moff[m];
    if (pos < 0 || pos > POS_MAX) begin
      send_query(random_query_pos());
      return;
    end
    flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < len; k++) begin
      v = sb.motif_mem[m][k];
      if (k == flip) v = v ^ (8'd1 << $urandom_range(0, 7));
      send_beat(amm_pkg::ACT_SEQ_WR, start + k, 0, 0, v, 0, 0);
    end
    send_query(pos);
  endtask

  // Drop valid, wait for every result, then let trailing loads finish
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Setup then access cycle; the register takes the value when pready is seen
  task automatic apb_write(input int idx, input int value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(REG_STRIDE * idx);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, pwdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(input int seq_len, input int in_use, input int n_beats,
                           input bit long_hold);
    int last_beat, pick;
    settle();
    apb_write(REG_SEQ_LEN, seq_len);
    apb_write(REG_IN_USE, in_use);
    // the sink counts this down while we keep offering beats
    if (long_hold) rx_hold_left = LONG_HOLD;
    last_beat = beats_sent + n_beats;
    while (beats_sent < last_beat) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        plant_and_query();
      else if (pick < 55)
        send_beat(amm_pkg::ACT_SHAPE_WR, 0, $urandom_range(0, 7), 0, 0,
                  $urandom_range(0, 31),
                  $urandom_range(0, 1) ? int'($urandom_range(0, 40)) - 20
                                       : int'($urandom_range(0, 511)));
      else if (pick < 70)
        send_beat(amm_pkg::ACT_CHAR_WR, 0, $urandom_range(0, 7), $urandom_range(0, 15),
                  $urandom, 0, 0);
      else if (pick < 80)
        send_beat(amm_pkg::ACT_SEQ_WR, $urandom_range(0, 1) ? random_query_pos()
                                                            : $urandom_range(0, POS_MAX),
                  0, 0, $urandom, 0, 0);
      else
        send_query(random_query_pos());
    end
  endtask

  // Result sink: stall for a drawn number of cycles after each result beat,
  // or for the long hold-off when one is requested.
  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(matched, query_position);
        gap_left = draw_gap();
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** anchored_motif_match_checker: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // No motif in use straight after reset: a query must report no match
    send_query(0);

    settle();
    apb_write(REG_SEQ_LEN, 32);
    apb_write(REG_IN_USE, 2);

    // Motif 0: four characters covering both byte extremes, offset zero
    send_beat(amm_pkg::ACT_SHAPE_WR, 0, 0, 0, 0, 4, 0);
    send_beat(amm_pkg::ACT_CHAR_WR, 0, 0, 0, 8'h00, 0, 0);
    send_beat(amm_pkg::ACT_CHAR_WR, 0, 0, 1, 8'hFF, 0, 0);
    send_beat(amm_pkg::ACT_CHAR_WR, 0, 0, 2, 8'h5A, 0, 0);
    send_beat(amm_pkg::ACT_CHAR_WR, 0, 0, 3, 8'hA5, 0, 0);
    send_beat(amm_pkg::ACT_SEQ_WR, 10, 0, 0, 8'h00, 0, 0);
    send_beat(amm_pkg::ACT_SEQ_WR, 11, 0, 0, 8'hFF, 0, 0);
    send_beat(amm_pkg::ACT_SEQ_WR, 12, 0, 0, 8'h5A, 0, 0);
    send_beat(amm_pkg::ACT_SEQ_WR, 13, 0, 0, 8'hA5, 0, 0);
    send_query(10);
    send_query(13);
    // Positive offset: start falls below zero at 10, lands on the copy at 30
    send_beat(amm_pkg::ACT_SHAPE_WR, 0, 0, 0, 0, 4, 20);
    send_query(10);
    send_query(30);
    // Over-long length saturates; most negative offset pushes past the end
    send_beat(amm_pkg::ACT_SHAPE_WR, 0, 1, 0, 0, 31, -256);
    send_query(0);
    send_beat(amm_pkg::ACT_CHAR_WR, 0, 7, 15, 8'hFF, 0, 0);
    send_query(POS_MAX);
    // Empty motif never matches
    send_beat(amm_pkg::ACT_SHAPE_WR, 0, 0, 0, 0, 0, 0);
    send_query(10);
    send_beat(amm_pkg::ACT_SHAPE_WR, 0, 0, 0, 0, 16, 255);
    send_query(POS_MAX);

    run_phase(64, 2, 170, 1'b0);
    run_phase(0, 8, 170, 1'b0);
    run_phase(amm_pkg::SEQ_DEPTH, 8, 170, 1'b1);
    run_phase(131071, 15, 170, 1'b0);
    run_phase(1, 1, 170, 1'b0);
    run_phase(300, 4, 170, 1'b1);
    run_phase(65535, 3, 170, 1'b0);
    run_phase(20, 8, 170, 1'b0);

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** anchored_motif_match_checker: PASSED **");
    end else begin
      $display("** anchored_motif_match_checker: FAILED **");
    end
    $finish;
  end

endmodule
